// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the rtl files
// each macro samples on clk and is switched off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define SCKPF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SCKPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sckpf_pkg.sv =====
// ---------------------------------------------------------------------------
// sckpf_pkg
// Types, constants and the height correction shared by the strip crosstalk
// peak finder modules.
// ---------------------------------------------------------------------------
package sckpf_pkg;

  // one strip record
  typedef struct packed {
    logic               digi_present;
    logic signed [15:0] pulse_height;
    logic [2:0]         peak_bin;
    logic [11:0]        sample_three;
    logic [11:0]        sample_four;
    logic               end_of_layer;
  } in_item_t;

  // one reported maximum or end marker
  typedef struct packed {
    logic               found;
    logic [6:0]         strip_index;
    logic signed [15:0] corrected_height;
    logic [2:0]         max_peak_bin;
    logic               last;
  } out_item_t;

  // configuration register map
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_CROSSTALK = 2'd1;

  localparam logic [15:0] PEAK_THRESHOLD_RST = 16'd480;

  // crosstalk arithmetic, levels in 1/16 counts, slope in Q2.8
  localparam int          LEVEL_W    = 13;
  localparam int          DIV_STEPS  = 11;
  localparam logic [22:0] XT_FACTOR  = 23'd1704;
  localparam logic [9:0]  SLOPE_MAX  = 10'd640;
  localparam logic [10:0] SLOPE_BASE = 11'd256;
  localparam logic [11:0] SAMPLE_MIN = 12'd10;

  // accepted peak time bins
  localparam logic [2:0] BIN_LO = 3'd2;
  localparam logic [2:0] BIN_HI = 3'd6;

  // result slots: strip p-2, strip p-1 and the final strip p
  localparam logic [1:0] SLOT_INNER = 2'd0;
  localparam logic [1:0] SLOT_PREV  = 2'd1;
  localparam logic [1:0] SLOT_FINAL = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       div_step;
    logic       mul;
    logic       shift;
    logic       flush;
    logic       test;
    logic [1:0] slot;
    logic       emit;
    logic       marker;
    logic       finish;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       eol;
    logic [2:0] hit;
    logic       can_load;
  } dp_stat_t;

  // raw + 2*mid - left - right, saturated; raw kept when skipped or not positive
  function automatic logic signed [15:0] corr_height(
    input logic signed [15:0] raw,
    input logic [LEVEL_W-1:0] lvl_left,
    input logic [LEVEL_W-1:0] lvl_mid,
    input logic [LEVEL_W-1:0] lvl_right,
    input logic               skip
  );
    logic signed [18:0] acc;
    logic signed [15:0] res;
    acc = {{3{raw[15]}}, raw} + {5'b0, lvl_mid, 1'b0} - {6'b0, lvl_left}
          - {6'b0, lvl_right};
    if (skip || raw <= 16'sd0) begin
      res = raw;
    end else if (acc > 19'sd32767) begin
      res = 16'sh7fff;
    end else if (acc < -19'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = acc[15:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/strip_crosstalk_peak_finder.sv =====
// ---------------------------------------------------------------------------
// strip_crosstalk_peak_finder
// Crosstalk correction over a three-strip window and local maximum search
// for one detector layer, with a register port for threshold and factor.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_ready   in_item_t, one strip record
//   out_     output     out_valid / out_ready out_item_t, maximum or marker
//   cfg_     input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// From one acceptance to the next a strip passes through the accepting
// cycle, the divider of the sample ratio at one quotient bit per cycle,
// then multiply, window shift, maximum test and emit.
// The final strip of a layer adds flush and two tests, then visits each
// result slot in turn, emitting those with a maximum, plus an end marker.
// Results leave through a single output register; an emit waits while it is
// full and out_ready is low, so out_ready low stalls the sequence there.
// Reset is synchronous: it clears the strip counter and control state and
// sets the threshold to 480 and the halving flag to 0. No clearing pass.
// ---------------------------------------------------------------------------
module strip_crosstalk_peak_finder
  import sckpf_pkg::*;
#(
  parameter int NUM_STRIPS = 128
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [15:0] peak_threshold_r;
  logic        half_crosstalk_r;
  dp_cmd_t     cmd;
  dp_stat_t    stat;

  // configuration registers, writes always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_threshold_r <= PEAK_THRESHOLD_RST;
      half_crosstalk_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PEAK_THRESHOLD: peak_threshold_r <= cfg_data;
        CFG_HALF_CROSSTALK: half_crosstalk_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sequencer
  sckpf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  sckpf_dp #(
    .NUM_STRIPS (NUM_STRIPS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_data        (in_data),
    .cmd            (cmd),
    .stat           (stat),
    .peak_threshold (peak_threshold_r),
    .half_crosstalk (half_crosstalk_r),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data)
  );

endmodule

// ===== rtl/sckpf_ctrl.sv =====
// ---------------------------------------------------------------------------
// sckpf_ctrl
// Sequencer for one strip: divider iterations, level multiply, window shift,
// maximum tests, layer flush and result emission.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sckpf_ctrl
  import sckpf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIV   = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_SHIFT = 4'd3;
  localparam logic [3:0] S_TEST0 = 4'd4;
  localparam logic [3:0] S_FLUSH = 4'd5;
  localparam logic [3:0] S_TEST1 = 4'd6;
  localparam logic [3:0] S_TEST2 = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;
  localparam logic [3:0] S_MARK  = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic [3:0] step_r, step_nxt;
  logic [1:0] slot_r, slot_nxt;
  logic [1:0] last_slot;

  assign in_ready  = (state_r == S_IDLE);
  assign last_slot = stat.eol ? SLOT_FINAL : SLOT_INNER;

  // next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    slot_nxt  = slot_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          step_nxt  = 4'(DIV_STEPS - 1);
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (step_r == 4'd0) begin
          state_nxt = S_MUL;
        end else begin
          step_nxt = step_r - 4'd1;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        state_nxt = S_TEST0;
      end
      S_TEST0: begin
        cmd.test  = 1'b1;
        cmd.slot  = SLOT_INNER;
        slot_nxt  = SLOT_INNER;
        state_nxt = stat.eol ? S_FLUSH : S_EMIT;
      end
      S_FLUSH: begin
        cmd.flush = 1'b1;
        state_nxt = S_TEST1;
      end
      S_TEST1: begin
        cmd.test  = 1'b1;
        cmd.slot  = SLOT_PREV;
        state_nxt = S_TEST2;
      end
      S_TEST2: begin
        cmd.test  = 1'b1;
        cmd.slot  = SLOT_FINAL;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        cmd.slot = slot_r;
        if (!(stat.hit[slot_r] && !stat.can_load)) begin
          cmd.emit = stat.hit[slot_r];
          if (slot_r == last_slot) begin
            if (stat.eol && stat.hit == 3'b000) begin
              state_nxt = S_MARK;
            end else begin
              cmd.finish = 1'b1;
              state_nxt  = S_IDLE;
            end
          end else begin
            slot_nxt = slot_r + 2'd1;
          end
        end
      end
      S_MARK: begin
        if (stat.can_load) begin
          cmd.emit   = 1'b1;
          cmd.marker = 1'b1;
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      slot_r  <= SLOT_INNER;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      slot_r  <= slot_nxt;
    end
  end

  // checks
  `SCKPF_ASSERT_NEXT(a_busy_after_load, cmd.load, !in_ready, "item taken while busy")
  `SCKPF_ASSERT_NEXT(a_idle_after_finish, cmd.finish, in_ready, "no return to idle")
  `SCKPF_ASSERT_IMPL(a_marker_on_eol, cmd.marker, stat.eol && stat.hit == 3'b000,
                     "end marker outside layer end")

endmodule

// ===== rtl/sckpf_dp.sv =====
// ---------------------------------------------------------------------------
// sckpf_dp
// Datapath: sample ratio divider, crosstalk level multiplier, strip windows,
// height correction, maximum test, result slots and output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sckpf_dp
  import sckpf_pkg::*;
#(
  parameter int NUM_STRIPS = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  in_item_t    in_data,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  logic [15:0] peak_threshold,
  input  logic        half_crosstalk,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  localparam int CNT_W = $clog2(NUM_STRIPS);
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [CNT_W:0]   qx_t;

  // item and divider registers
  logic signed [15:0]   h_r;
  logic [2:0]           bin_r;
  logic                 eol_r;
  logic                 xt_zero_r;
  logic [23:0]          rem_r;
  logic [25:0]          dsh_r;
  logic [10:0]          quo_r;
  logic                 sat_r;
  logic [22:0]          prod1_r;
  logic [LEVEL_W-1:0]   level_r, level_nxt;

  // strip windows, oldest at index 0
  logic signed [15:0]   raw_w_r [3];
  logic [LEVEL_W-1:0]   xt_w_r  [3];
  logic [2:0]           bin_w_r [3];
  logic signed [15:0]   cor_w_r [3];
  cnt_t                 cnt_r;

  // result slots and output register
  logic [2:0]           res_hit_r;
  logic [6:0]           res_idx_r [3];
  logic signed [15:0]   res_h_r   [3];
  logic [2:0]           res_bin_r [3];
  logic                 out_valid_r;
  out_item_t            out_data_r;

  // accept-time divider setup: dividend 2560*s4, divisor 10*s3+1
  logic [15:0] div_in;
  logic [23:0] dividend;
  logic        sat_nxt;
  logic        div_ge;
  logic        eol_nxt;

  assign div_in   = ({4'b0, in_data.sample_three} << 3) + ({4'b0, in_data.sample_three} << 1)
                    + 16'd1;
  assign dividend = ({12'b0, in_data.sample_four} << 11) + ({12'b0, in_data.sample_four} << 9);
  assign sat_nxt  = ({3'b0, dividend} >= {div_in, 11'b0});
  assign div_ge   = ({2'b0, rem_r} >= dsh_r);
  assign eol_nxt  = in_data.end_of_layer || (cnt_r == cnt_t'(NUM_STRIPS - 1));

  // slope clamp and level multiply
  logic [10:0] diff;
  logic [9:0]  slope;
  logic [32:0] prod;

  always_comb begin
    diff = quo_r - SLOPE_BASE;
    if (sat_r) begin
      slope = SLOPE_MAX;
    end else if (quo_r < SLOPE_BASE) begin
      slope = '0;
    end else if (diff > {1'b0, SLOPE_MAX}) begin
      slope = SLOPE_MAX;
    end else begin
      slope = diff[9:0];
    end
    prod = 33'(prod1_r) * 33'(slope);
    if (xt_zero_r) begin
      level_nxt = '0;
    end else if (half_crosstalk) begin
      level_nxt = {1'b0, prod[32:21]};
    end else begin
      level_nxt = prod[32:20];
    end
  end

  // height correction of strip p-1 on shift, of the final strip on flush
  logic               corr_skip;
  logic signed [15:0] cor_nxt;

  always_comb begin
    if (cmd.flush) begin
      corr_skip = (cnt_r == cnt_t'(0));
      cor_nxt   = corr_height(raw_w_r[2], xt_w_r[1], xt_w_r[2], '0, corr_skip);
    end else begin
      corr_skip = (cnt_r == cnt_t'(1));
      if (cnt_r == cnt_t'(0)) begin
        cor_nxt = '0;
      end else begin
        cor_nxt = corr_height(raw_w_r[2], xt_w_r[1], xt_w_r[2], level_r, corr_skip);
      end
    end
  end

  // local maximum test for the selected slot
  logic signed [15:0] t_left, t_mid, t_right;
  logic               t_has_right;
  logic [2:0]         t_bin;
  qx_t                t_off, t_q;
  logic [8:0]         t_idx9;
  logic signed [17:0] t_sum;
  logic               t_hit;

  always_comb begin
    t_left      = cor_w_r[0];
    t_mid       = cor_w_r[1];
    t_right     = cor_w_r[2];
    t_has_right = 1'b1;
    t_bin       = bin_w_r[0];
    t_off       = qx_t'(2);
    unique case (cmd.slot)
      SLOT_INNER: begin
        t_bin = bin_w_r[0];
        t_off = qx_t'(2);
      end
      SLOT_PREV: begin
        t_bin = bin_w_r[1];
        t_off = qx_t'(1);
      end
      SLOT_FINAL: begin
        t_left      = cor_w_r[1];
        t_mid       = cor_w_r[2];
        t_has_right = 1'b0;
        t_bin       = bin_w_r[2];
        t_off       = qx_t'(0);
      end
      default: begin
        t_off = qx_t'(2);
      end
    endcase
    t_q    = {1'b0, cnt_r} - t_off;
    t_idx9 = 9'(t_q[CNT_W-1:0]);
    t_sum  = 18'(t_left) + 18'(t_mid) + (t_has_right ? 18'(t_right) : 18'sd0);
    t_hit  = !t_q[CNT_W] && (t_q != qx_t'(0))
             && (t_sum > $signed({2'b0, peak_threshold}))
             && (t_mid > t_left)
             && (!t_has_right || t_mid >= t_right)
             && (t_bin >= BIN_LO) && (t_bin <= BIN_HI);
  end

  // last flag: end of layer with no later slot holding a maximum
  logic can_load;
  logic emit_last;

  assign can_load = !out_valid_r || out_ready;

  always_comb begin
    unique case (cmd.slot)
      SLOT_INNER: emit_last = eol_r && (res_hit_r[2:1] == 2'b00);
      SLOT_PREV:  emit_last = eol_r && !res_hit_r[2];
      SLOT_FINAL: emit_last = eol_r;
      default:    emit_last = eol_r;
    endcase
  end

  // item capture, divider iterations, level
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      h_r       <= in_data.pulse_height;
      bin_r     <= in_data.peak_bin;
      eol_r     <= eol_nxt;
      xt_zero_r <= !in_data.digi_present || (in_data.sample_four < SAMPLE_MIN);
      rem_r     <= dividend;
      dsh_r     <= {div_in, 10'b0};
      quo_r     <= '0;
      sat_r     <= sat_nxt;
      prod1_r   <= 23'(in_data.sample_four) * XT_FACTOR;
    end
    if (cmd.div_step) begin
      if (div_ge) begin
        rem_r <= rem_r - dsh_r[23:0];
      end
      quo_r <= {quo_r[9:0], div_ge};
      dsh_r <= dsh_r >> 1;
    end
    if (cmd.mul) begin
      level_r <= level_nxt;
    end
  end

  // strip windows and corrected heights
  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      raw_w_r <= '{raw_w_r[1], raw_w_r[2], h_r};
      xt_w_r  <= '{xt_w_r[1], xt_w_r[2], level_r};
      bin_w_r <= '{bin_w_r[1], bin_w_r[2], bin_r};
    end
    if (cmd.shift || cmd.flush) begin
      cor_w_r <= '{cor_w_r[1], cor_w_r[2], cor_nxt};
    end
    if (cmd.test) begin
      res_idx_r[cmd.slot] <= t_idx9[6:0];
      res_h_r[cmd.slot]   <= t_mid;
      res_bin_r[cmd.slot] <= t_bin;
    end
  end

  // strip counter, hit flags and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      res_hit_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        res_hit_r <= '0;
      end else if (cmd.test) begin
        res_hit_r[cmd.slot] <= t_hit;
      end
      if (cmd.finish) begin
        cnt_r <= eol_r ? '0 : cnt_r + cnt_t'(1);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (cmd.marker) begin
        out_data_r <= '{found: 1'b0, strip_index: '0, corrected_height: '0,
                        max_peak_bin: '0, last: 1'b1};
      end else begin
        out_data_r <= '{found: 1'b1, strip_index: res_idx_r[cmd.slot],
                        corrected_height: res_h_r[cmd.slot],
                        max_peak_bin: res_bin_r[cmd.slot], last: emit_last};
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign stat.eol      = eol_r;
  assign stat.hit      = res_hit_r;
  assign stat.can_load = can_load;

  // checks
  `SCKPF_ASSERT_IMPL(a_emit_room, cmd.emit, can_load, "output register overwritten")
  `SCKPF_ASSERT_IMPL(a_marker_last, out_valid_r && !out_data_r.found, out_data_r.last,
                     "end marker without last")
  `SCKPF_ASSERT_NEXT(a_cnt_cleared, cmd.finish && eol_r, cnt_r == cnt_t'(0),
                     "strip counter not cleared at layer end")

endmodule
